/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BBPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BBPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bbps_pkg.sv */
// ---------------------------------------------------------------------------
// bbps_pkg
// shared constants, types and match functions of the byte buffer search
// ---------------------------------------------------------------------------
`default_nettype none

package bbps_pkg;

	localparam int unsigned STORE_DEPTH = 4096;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned FILL_W      = ADDR_W + 1;
	localparam int unsigned MAX_PATTERN = 8;
	localparam int unsigned PLEN_W      = 4;
	localparam int unsigned PAT_W       = 8 * MAX_PATTERN;
	localparam int unsigned MAX_RANGE   = 64;
	localparam int unsigned RLEN_W      = 7;
	localparam int unsigned APB_AW      = 4;
	localparam int unsigned APB_DW      = 64;

	typedef enum logic [1:0] {
		CMD_APPEND     = 2'd0,
		CMD_READ       = 2'd1,
		CMD_FIND_FIRST = 2'd2,
		CMD_FIND_LAST  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef enum logic {
		REG_PATTERN = 1'b0,
		REG_LENGTH  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PAT_W-1:0]  pattern;
		logic [PLEN_W-1:0] plen;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  result_byte;
		logic        found;
		logic [11:0] match_index;
		logic [12:0] fill_count;
		logic [1:0]  error_code;
		logic        last_of_run;
	} out_word_t;

	function automatic logic [PLEN_W-1:0] eff_len(input logic [PLEN_W-1:0] raw);
		logic [PLEN_W-1:0] n;
		n = raw;
		if (n == '0)
			n = PLEN_W'(1);
		if (n > PLEN_W'(MAX_PATTERN))
			n = PLEN_W'(MAX_PATTERN);
		return n;
	endfunction

	// hist byte j holds store[a-j]; pattern byte k must sit at hist byte plen-1-k
	function automatic logic match_fwd(input logic [PAT_W-1:0] hist,
			input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] plen);
		logic ok;
		int   idx;
		ok = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx = int'(plen) - 1 - k;
			if (k < int'(plen)) begin
				if (hist[8*idx +: 8] != pat[8*k +: 8])
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// hist byte j holds store[a+j]
	function automatic logic match_bwd(input logic [PAT_W-1:0] hist,
			input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] plen);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (k < int'(plen)) begin
				if (hist[8*k +: 8] != pat[8*k +: 8])
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

/* hdl/bbps_if.sv */
// ---------------------------------------------------------------------------
// bbps_if
// valid/ready channels for command words and result words
// ---------------------------------------------------------------------------
`default_nettype none

interface bbps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic [11:0] start_index;
	logic [6:0]  range_length;

	modport source (output valid, command, data_byte, start_index, range_length,
		input ready);
	modport sink (input valid, command, data_byte, start_index, range_length,
		output ready);
endinterface

interface bbps_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  result_byte;
	logic        found;
	logic [11:0] match_index;
	logic [12:0] fill_count;
	logic [1:0]  error_code;
	logic        last_of_run;

	modport source (output valid, result_byte, found, match_index, fill_count,
		error_code, last_of_run, input ready);
	modport sink (input valid, result_byte, found, match_index, fill_count,
		error_code, last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/bbps_ram.sv */
// ---------------------------------------------------------------------------
// bbps_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module bbps_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned WIDTH = 8,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/bbps_cfg.sv */
// ---------------------------------------------------------------------------
// bbps_cfg
// apb register file holding the search pattern and its length
// ---------------------------------------------------------------------------
`default_nettype none

module bbps_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bbps_pkg::APB_AW-1:0] paddr,
	input  wire logic [bbps_pkg::APB_DW-1:0] pwdata,
	output logic      [bbps_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	output bbps_pkg::cfg_t                   cfg
);

	logic [bbps_pkg::PAT_W-1:0]  pattern_q;
	logic [bbps_pkg::PLEN_W-1:0] length_q;
	bbps_pkg::reg_idx_t          sel;
	logic                        wr;

	assign pready = 1'b1;
	assign sel    = bbps_pkg::reg_idx_t'(paddr[3]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= bbps_pkg::PLEN_W'(1);
		end else if (wr) begin
			case (sel)
				bbps_pkg::REG_PATTERN: pattern_q <= pwdata[bbps_pkg::PAT_W-1:0];
				bbps_pkg::REG_LENGTH:  length_q  <= pwdata[bbps_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			bbps_pkg::REG_PATTERN: prdata = bbps_pkg::APB_DW'(pattern_q);
			bbps_pkg::REG_LENGTH:  prdata = bbps_pkg::APB_DW'(length_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.pattern = pattern_q;
	assign cfg.plen    = bbps_pkg::eff_len(length_q);

endmodule

`default_nettype wire

/* hdl/bbps_ctrl.sv */
// ---------------------------------------------------------------------------
// bbps_ctrl
// command sequencer: appends, range reads and byte-serial pattern scans
// ---------------------------------------------------------------------------
`default_nettype none

module bbps_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bbps_in_if.sink                           in_ch,
	bbps_out_if.source                        out_ch,
	input  bbps_pkg::cfg_t                    cfg,
	output logic                              ram_we,
	output logic      [bbps_pkg::ADDR_W-1:0]  ram_waddr,
	output logic      [7:0]                   ram_wdata,
	output logic                              ram_re,
	output logic      [bbps_pkg::ADDR_W-1:0]  ram_raddr,
	input  wire logic [7:0]                   ram_rdata
);

	localparam int unsigned AW = bbps_pkg::ADDR_W;
	localparam int unsigned FW = bbps_pkg::FILL_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RANGE,
		S_SCAN
	} state_t;

	state_t                      state_q;
	logic [FW-1:0]               fill_q;
	logic [AW-1:0]               addr_q;
	logic [AW-1:0]               end_q;
	logic                        back_q;
	logic [bbps_pkg::PLEN_W-1:0] plen_q;
	logic [bbps_pkg::PAT_W-1:0]  hist_q;
	logic [bbps_pkg::PLEN_W-1:0] seen_q;
	logic                        out_valid_q;
	bbps_pkg::out_word_t         out_q;

	bbps_pkg::cmd_t              cmd;
	logic                        out_free;
	logic                        accept;
	logic                        full;
	logic [FW-1:0]               fill_m1;
	logic [FW-1:0]               range_top;
	logic                        range_bad;
	logic                        too_short;
	logic [bbps_pkg::PAT_W-1:0]  hist_nx;
	logic [bbps_pkg::PLEN_W-1:0] seen_nx;
	logic                        hit;
	logic                        scan_end;
	logic [AW-1:0]               hit_idx;
	logic [AW-1:0]               scan_next;
	logic                        load;
	bbps_pkg::out_word_t         word;

	assign cmd       = bbps_pkg::cmd_t'(in_ch.command);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;
	assign accept    = in_ch.valid && in_ch.ready;

	assign full      = (fill_q == FW'(bbps_pkg::STORE_DEPTH));
	assign fill_m1   = fill_q - FW'(1);
	assign range_top = FW'(in_ch.start_index) + FW'(in_ch.range_length);
	assign range_bad = (in_ch.range_length == '0)
		|| (in_ch.range_length > bbps_pkg::RLEN_W'(bbps_pkg::MAX_RANGE))
		|| (range_top > fill_q);
	assign too_short = (fill_q < FW'(cfg.plen));

	// scan window: newest byte enters at byte 0
	assign hist_nx  = {hist_q[bbps_pkg::PAT_W-9:0], ram_rdata};
	assign seen_nx  = (seen_q == bbps_pkg::PLEN_W'(bbps_pkg::MAX_PATTERN)) ?
		seen_q : seen_q + bbps_pkg::PLEN_W'(1);
	assign hit      = (seen_nx >= plen_q) && (back_q ?
		bbps_pkg::match_bwd(hist_nx, cfg.pattern, plen_q) :
		bbps_pkg::match_fwd(hist_nx, cfg.pattern, plen_q));
	assign scan_end = back_q ? (addr_q == '0) : (addr_q == fill_m1[AW-1:0]);
	assign hit_idx  = back_q ? addr_q : addr_q - AW'(plen_q) + AW'(1);
	assign scan_next = back_q ? addr_q - AW'(1) : addr_q + AW'(1);

	assign ram_we    = accept && (cmd == bbps_pkg::CMD_APPEND) && !full;
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_wdata = in_ch.data_byte;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_q + AW'(1);
		load      = 1'b0;
		word      = '0;
		word.fill_count  = fill_q;
		word.last_of_run = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						bbps_pkg::CMD_APPEND: begin
							load = 1'b1;
							if (full)
								word.error_code = bbps_pkg::ERR_FULL;
							else
								word.fill_count = fill_q + FW'(1);
						end
						bbps_pkg::CMD_READ: begin
							if (range_bad) begin
								load = 1'b1;
								word.error_code = bbps_pkg::ERR_RANGE;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(in_ch.start_index);
							end
						end
						bbps_pkg::CMD_FIND_FIRST: begin
							if (too_short)
								load = 1'b1;
							else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
							end
						end
						bbps_pkg::CMD_FIND_LAST: begin
							if (too_short)
								load = 1'b1;
							else begin
								ram_re    = 1'b1;
								ram_raddr = fill_m1[AW-1:0];
							end
						end
						default: ;
					endcase
				end
			end
			S_RANGE: begin
				if (out_free) begin
					load = 1'b1;
					word.result_byte = ram_rdata;
					word.last_of_run = (addr_q == end_q);
					if (addr_q != end_q)
						ram_re = 1'b1;
				end
			end
			S_SCAN: begin
				ram_raddr = scan_next;
				if (hit || scan_end) begin
					load = out_free;
					word.found       = hit;
					word.match_index = hit ? hit_idx : '0;
				end else
					ram_re = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			addr_q      <= '0;
			end_q       <= '0;
			back_q      <= 1'b0;
			plen_q      <= bbps_pkg::PLEN_W'(1);
			hist_q      <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				out_q       <= word;
			end else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (ram_we)
							fill_q <= fill_q + FW'(1);
						if (ram_re) begin
							addr_q <= ram_raddr;
							end_q  <= AW'(in_ch.start_index) + AW'(in_ch.range_length)
								- AW'(1);
							back_q <= (cmd == bbps_pkg::CMD_FIND_LAST);
							plen_q <= cfg.plen;
							seen_q <= '0;
							state_q <= (cmd == bbps_pkg::CMD_READ) ? S_RANGE : S_SCAN;
						end
					end
				end
				S_RANGE: begin
					if (out_free) begin
						if (addr_q == end_q)
							state_q <= S_IDLE;
						else
							addr_q <= addr_q + AW'(1);
					end
				end
				S_SCAN: begin
					if (hit || scan_end) begin
						if (out_free)
							state_q <= S_IDLE;
					end else begin
						hist_q <= hist_nx;
						seen_q <= seen_nx;
						addr_q <= scan_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_byte = out_q.result_byte;
	assign out_ch.found       = out_q.found;
	assign out_ch.match_index = out_q.match_index;
	assign out_ch.fill_count  = out_q.fill_count;
	assign out_ch.error_code  = out_q.error_code;
	assign out_ch.last_of_run = out_q.last_of_run;

endmodule

`default_nettype wire

/* hdl/byte_buffer_pattern_search.sv */
// ---------------------------------------------------------------------------
// byte_buffer_pattern_search
// byte store with fill count, range reads and first/last pattern search
//
//   channel  dir  handshake       carries
//   in_ch    in   valid/ready     command, data_byte, start_index, range_length
//   out_ch   out  valid/ready     result word per byte or per command
//   apb      in   psel/penable    pattern_bytes @0x0, pattern_length @0x8
//
// append: one word per cycle unless out_ch stalls, result in the output
//   register the next cycle; read range: one ram read ahead, then one word
//   per cycle unless out_ch stalls; input held off; find: one byte per cycle
//   through the single ram read port; stops at the first hit in scan order
// reset clears the fill count, not the store; the store needs no clearing pass
// a stalled output word holds, and in_ch.ready stays low until it drains
// ---------------------------------------------------------------------------
`default_nettype none

module byte_buffer_pattern_search (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bbps_in_if.sink                          in_ch,
	bbps_out_if.source                       out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bbps_pkg::APB_AW-1:0] paddr,
	input  wire logic [bbps_pkg::APB_DW-1:0] pwdata,
	output logic      [bbps_pkg::APB_DW-1:0] prdata,
	output logic                             pready
);

	bbps_pkg::cfg_t                cfg;
	logic                          ram_we;
	logic [bbps_pkg::ADDR_W-1:0]   ram_waddr;
	logic [7:0]                    ram_wdata;
	logic                          ram_re;
	logic [bbps_pkg::ADDR_W-1:0]   ram_raddr;
	logic [7:0]                    ram_rdata;

	bbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bbps_ram #(
		.DEPTH (bbps_pkg::STORE_DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg       (cfg),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* hdl/bbps_checker.sv */
// ---------------------------------------------------------------------------
// bbps_checker
// port-level checks on result words, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bbps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  result_byte,
	input wire logic        found,
	input wire logic [11:0] match_index,
	input wire logic [12:0] fill_count,
	input wire logic [1:0]  error_code,
	input wire logic        last_of_run
);

	`BBPS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_byte) && $stable(match_index) && $stable(fill_count) && $stable(error_code) && $stable(last_of_run) && $stable(found), "stalled word changed")
	`BBPS_ASSERT_IMP(a_err_word, clk, arst_n, out_valid && (error_code != 2'd0), last_of_run && (result_byte == 8'd0) && !found && (match_index == 12'd0), "error word not clean")
	`BBPS_ASSERT_IMP(a_no_hit_idx, clk, arst_n, out_valid && !found, match_index == 12'd0, "index without hit")
	`BBPS_ASSERT_IMP(a_run_busy, clk, arst_n, out_valid && !last_of_run, !in_ready, "input taken during run")

endmodule

bind byte_buffer_pattern_search bbps_checker u_bbps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.result_byte (out_ch.result_byte),
	.found       (out_ch.found),
	.match_index (out_ch.match_index),
	.fill_count  (out_ch.fill_count),
	.error_code  (out_ch.error_code),
	.last_of_run (out_ch.last_of_run)
);

`default_nettype wire

/* sim/byte_buffer_pattern_search_tb.sv */
// ---------------------------------------------------------------------------
// byte_buffer_pattern_search_tb
// self-checking bench for the byte buffer with first/last pattern search
//
// a scoreboard class mirrors the store, the fill count and both registers,
// and predicts every result word of each accepted command word. directed
// words cover the empty store, match at index 0 both ways, bad read ranges,
// pattern length clamping and a pattern longer than the contents. random
// phases then vary sender gaps and receiver stalls and pick new patterns,
// mostly taken from the store so that searches hit.
// ---------------------------------------------------------------------------

module byte_buffer_pattern_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	class bbps_scoreboard;
		logic [7:0]          store_bytes [bbps_pkg::STORE_DEPTH];
		int unsigned         fill;
		logic [63:0]         pattern;
		logic [3:0]          plen_raw;
		bbps_pkg::out_word_t pending_words [$];
		int unsigned         errors;

		function new();
			fill     = 0;
			pattern  = '0;
			plen_raw = 4'd1;
			errors   = 0;
		endfunction

		function void set_register(bbps_pkg::reg_idx_t idx, logic [63:0] value);
			if (idx == bbps_pkg::REG_PATTERN)
				pattern = value;
			else
				plen_raw = value[3:0];
		endfunction

		function int unsigned pattern_len();
			if (plen_raw == 4'd0)
				return 1;
			if (plen_raw > bbps_pkg::MAX_PATTERN)
				return bbps_pkg::MAX_PATTERN;
			return plen_raw;
		endfunction

		function bit matches_at(int unsigned pos, int unsigned n);
			for (int k = 0; k < n; k++) begin
				if (store_bytes[pos + k] !== pattern[8*k +: 8])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function bbps_pkg::out_word_t make_word(logic [7:0] b, logic f, logic [11:0] idx,
				bbps_pkg::err_t err, logic last);
			bbps_pkg::out_word_t w;
			w.result_byte = b;
			w.found       = f;
			w.match_index = idx;
			w.fill_count  = 13'(fill);
			w.error_code  = err;
			w.last_of_run = last;
			return w;
		endfunction

		function void note_command(bbps_pkg::cmd_t cmd, logic [7:0] db, logic [11:0] si,
				logic [6:0] rl);
			int unsigned n;
			int unsigned top;
			int unsigned where;
			bit          hit;
			hit   = 1'b0;
			where = 0;
			case (cmd)
				bbps_pkg::CMD_APPEND: begin
					if (fill >= bbps_pkg::STORE_DEPTH) begin
						pending_words.push_back(make_word(8'd0, 1'b0, 12'd0,
							bbps_pkg::ERR_FULL, 1'b1));
					end else begin
						store_bytes[fill] = db;
						fill++;
						pending_words.push_back(make_word(8'd0, 1'b0, 12'd0,
							bbps_pkg::ERR_OK, 1'b1));
					end
				end
				bbps_pkg::CMD_READ: begin
					if (rl == 7'd0 || rl > bbps_pkg::MAX_RANGE || 32'(si) + 32'(rl) > fill) begin
						pending_words.push_back(make_word(8'd0, 1'b0, 12'd0,
							bbps_pkg::ERR_RANGE, 1'b1));
					end else begin
						for (int k = 0; k < rl; k++)
							pending_words.push_back(make_word(store_bytes[si + k], 1'b0, 12'd0,
								bbps_pkg::ERR_OK, (k + 1 == rl)));
					end
				end
				default: begin
					n = pattern_len();
					if (fill >= n) begin
						top = fill - n;
						if (cmd == bbps_pkg::CMD_FIND_FIRST) begin
							for (int i = 0; i <= top; i++) begin
								if (matches_at(i, n)) begin
									hit   = 1'b1;
									where = i;
									break;
								end
							end
						end else begin
							for (int i = top; i >= 0; i--) begin
								if (matches_at(i, n)) begin
									hit   = 1'b1;
									where = i;
									break;
								end
							end
						end
					end
					pending_words.push_back(make_word(8'd0, hit, 12'(where),
						bbps_pkg::ERR_OK, 1'b1));
				end
			endcase
		endfunction

		function void compare_field(string name, logic [12:0] want, logic [12:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(bbps_pkg::out_word_t got);
			bbps_pkg::out_word_t want;
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected: %p", got);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			compare_field("result_byte", want.result_byte, got.result_byte);
			compare_field("found", want.found, got.found);
			compare_field("match_index", want.match_index, got.match_index);
			compare_field("fill_count", want.fill_count, got.fill_count);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bbps_pkg::APB_AW-1:0] paddr;
	logic [bbps_pkg::APB_DW-1:0] pwdata;
	logic [bbps_pkg::APB_DW-1:0] prdata;
	logic                        pready;

	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;

	bbps_scoreboard sb = new();

	bbps_in_if  in_ch ();
	bbps_out_if out_ch ();

	byte_buffer_pattern_search DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// outputs settle after the rising edge; a word seen here is taken at the next edge
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_result({out_ch.result_byte, out_ch.found, out_ch.match_index,
				out_ch.fill_count, out_ch.error_code, out_ch.last_of_run});
	end

	task automatic send_word(bbps_pkg::cmd_t cmd, logic [7:0] db, logic [11:0] si,
			logic [6:0] rl);
		logic acc;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		in_ch.valid        <= 1'b1;
		in_ch.command      <= cmd;
		in_ch.data_byte    <= db;
		in_ch.start_index  <= si;
		in_ch.range_length <= rl;
		forever begin
			@(negedge clk);
			acc = in_ch.ready;
			@(posedge clk);
			if (acc)
				break;
		end
		sb.note_command(cmd, db, si, rl);
	endtask

	task automatic append_byte(logic [7:0] db);
		send_word(bbps_pkg::CMD_APPEND, db, 12'($urandom), 7'($urandom));
	endtask

	task automatic search(bbps_pkg::cmd_t cmd);
		send_word(cmd, 8'($urandom), 12'($urandom), 7'($urandom));
	endtask

	task automatic read_range(int unsigned start, int unsigned len);
		send_word(bbps_pkg::CMD_READ, 8'($urandom), 12'(start), 7'(len));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(bbps_pkg::reg_idx_t idx, logic [63:0] value);
		logic acc;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bbps_pkg::APB_AW'(8 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			acc = pready;
			@(posedge clk);
			if (acc)
				break;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_register(idx, value);
	endtask

	task automatic set_pattern(logic [63:0] pat, logic [3:0] raw_len);
		drain();
		write_reg(bbps_pkg::REG_PATTERN, pat);
		write_reg(bbps_pkg::REG_LENGTH, 64'(raw_len));
	endtask

	// new pattern per phase, mostly cut from the store so that searches hit
	task automatic pick_pattern();
		int unsigned n;
		int unsigned pos;
		logic [63:0] pat;
		logic [3:0]  raw;
		n   = $urandom_range(1, bbps_pkg::MAX_PATTERN);
		pat = {$urandom, $urandom};
		if (sb.fill >= n && $urandom_range(99) < 75) begin
			pos = $urandom_range(sb.fill - n);
			for (int k = 0; k < n; k++)
				pat[8*k +: 8] = sb.store_bytes[pos + k];
		end
		raw = 4'(n);
		if (n == 1 && $urandom_range(1) == 1)
			raw = 4'd0;
		if (n == bbps_pkg::MAX_PATTERN && $urandom_range(1) == 1)
			raw = 4'($urandom_range(bbps_pkg::MAX_PATTERN + 1, 15));
		set_pattern(pat, raw);
	endtask

	task automatic run_random(int unsigned count);
		int unsigned sent;
		int unsigned pick;
		int unsigned n;
		int unsigned start;
		int unsigned len;
		int unsigned bad;
		logic [7:0]  b;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				b = 8'($urandom);
				if ($urandom_range(99) < 60)
					b = sb.pattern[8 * $urandom_range(sb.pattern_len() - 1) +: 8];
				append_byte(b);
				sent++;
			end else if (pick < 42) begin
				// whole pattern appended, now and then with one byte spoiled
				n   = sb.pattern_len();
				bad = ($urandom_range(99) < 30) ? $urandom_range(n - 1) : n;
				for (int k = 0; k < n; k++)
					append_byte((k == bad) ? 8'($urandom) : sb.pattern[8*k +: 8]);
				sent += n;
			end else if (pick < 66) begin
				if (sb.fill != 0 && $urandom_range(99) < 80) begin
					start = $urandom_range(sb.fill - 1);
					len   = sb.fill - start;
					if (len > bbps_pkg::MAX_RANGE)
						len = bbps_pkg::MAX_RANGE;
					len = $urandom_range(1, len);
				end else begin
					start = $urandom_range(bbps_pkg::STORE_DEPTH - 1);
					len   = $urandom_range(127);
				end
				read_range(start, len);
				sent++;
			end else begin
				search((pick < 83) ? bbps_pkg::CMD_FIND_FIRST : bbps_pkg::CMD_FIND_LAST);
				sent++;
			end
		end
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned count);
		pick_pattern();
		src_idle_pct  = idle;
		snk_stall_pct = stall;
		run_random(count);
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		in_ch.valid        = 1'b0;
		in_ch.command      = bbps_pkg::CMD_APPEND;
		in_ch.data_byte    = '0;
		in_ch.start_index  = '0;
		in_ch.range_length = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store with reset pattern
		search(bbps_pkg::CMD_FIND_FIRST);
		search(bbps_pkg::CMD_FIND_LAST);
		read_range(0, 1);
		append_byte(8'h00);
		search(bbps_pkg::CMD_FIND_FIRST);
		search(bbps_pkg::CMD_FIND_LAST);
		append_byte(8'hFF);
		append_byte(8'hA5);
		append_byte(8'h5A);
		append_byte(8'hFF);
		append_byte(8'hFF);
		read_range(0, 6);
		read_range(0, 0);
		read_range(0, bbps_pkg::MAX_RANGE + 1);
		read_range(0, 127);
		read_range(bbps_pkg::STORE_DEPTH - 1, bbps_pkg::MAX_RANGE);
		read_range(5, 1);

		// zero length acts as one byte
		set_pattern('1, 4'd0);
		search(bbps_pkg::CMD_FIND_FIRST);
		search(bbps_pkg::CMD_FIND_LAST);
		// oversize length clamps to eight, longer than contents
		set_pattern('1, 4'd15);
		search(bbps_pkg::CMD_FIND_FIRST);
		search(bbps_pkg::CMD_FIND_LAST);
		set_pattern(64'h5AA5, 4'd2);
		search(bbps_pkg::CMD_FIND_FIRST);
		search(bbps_pkg::CMD_FIND_LAST);

		run_phase(0, 0, 22);
		run_phase(65, 0, 22);
		run_phase(0, 65, 22);
		run_phase(31, 31, 22);

		drain();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
